[design/ptdt_pkg.sv]
`timescale 1ns / 1ps

package ptdt_pkg;

  localparam int IDX_W   = 4;
  localparam int CNT_W   = 5;
  localparam int TICK_W  = 32;
  localparam int SLOTS   = 16;

  // Counter value above which a timed poll wipes the schedule.
  localparam logic [TICK_W-1:0] WRAP_LIMIT = 32'd4294960000;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_CREATE  = 3'd1,
    OP_UPDATE  = 3'd2,
    OP_SUSPEND = 3'd3,
    OP_RESUME  = 3'd4,
    OP_POLL    = 3'd5
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // One slot of the schedule memory.
  typedef struct packed {
    logic [TICK_W-1:0] period;
    logic [TICK_W-1:0] due;
  } entry_t;

endpackage

[design/ptdt_ram.sv]
`timescale 1ns / 1ps

module ptdt_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  ptdt_pkg::entry_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output ptdt_pkg::entry_t rdata
);

  ptdt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/periodic_task_dispatch_table_unit.sv]
`timescale 1ns / 1ps
// Each item is taken in idle and its slot read; in exec the slot is updated and the
// result loaded once the output is free. No new item is taken until then, as the
// read-modify-write of the slot memory occupies the unit (read, then update).
// Reset (synchronous, rst high) zeroes the tick counter, the slot count and all
// slot flags except first-run, which sets; the wrap clear takes effect at once.
module periodic_task_dispatch_table_unit #(
  parameter int MAX_TASKS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [ptdt_pkg::CNT_W-1:0]     cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     op,
  input  logic [ptdt_pkg::IDX_W-1:0]     task_index,
  input  logic [ptdt_pkg::TICK_W-1:0]    period,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           status,
  output logic                           dispatched,
  output logic                           first_run,
  output logic [ptdt_pkg::IDX_W-1:0]     slot_out,
  output logic [ptdt_pkg::TICK_W-1:0]    tick_snapshot
);

  localparam int DEPTH = (MAX_TASKS < ptdt_pkg::SLOTS) ? MAX_TASKS : ptdt_pkg::SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [7:0] MAX_W = 8'(MAX_TASKS);

  ptdt_pkg::state_t state, state_next;

  logic [ptdt_pkg::CNT_W-1:0]  task_count;
  logic [ptdt_pkg::TICK_W-1:0] tick_count, tick_next;
  logic [DEPTH-1:0] ready_flag, ready_next;
  logic [DEPTH-1:0] untimed_flag, untimed_next;
  logic [DEPTH-1:0] first_flag, first_next;
  logic [DEPTH-1:0] suspended_flag, suspended_next;

  logic [2:0]                  item_op;
  logic [ptdt_pkg::IDX_W-1:0]  item_index;
  logic [ptdt_pkg::TICK_W-1:0] item_period;

  logic             in_fire, exec_fire;
  logic [AW-1:0]    aw;
  logic             in_range, indexed;
  logic             mem_we;
  ptdt_pkg::entry_t mem_wdata, mem_rdata;
  logic             res_status, res_disp, res_first;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state == ptdt_pkg::S_IDLE);
  assign exec_fire = (state == ptdt_pkg::S_EXEC) && (!out_valid || out_ready);
  assign aw        = item_index[AW-1:0];
  assign in_range  = ({4'd0, item_index} < MAX_W) && ({1'b0, item_index} < task_count);
  assign indexed   = (item_op != ptdt_pkg::OP_TICK) && (item_op <= ptdt_pkg::OP_POLL);

  ptdt_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (aw),
    .wdata (mem_wdata),
    .re    (in_fire),
    .raddr (task_index[AW-1:0]),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ptdt_pkg::S_IDLE: begin
        if (in_valid) state_next = ptdt_pkg::S_EXEC;
      end
      ptdt_pkg::S_EXEC: begin
        if (exec_fire) state_next = ptdt_pkg::S_IDLE;
      end
      default: state_next = ptdt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    tick_next      = tick_count;
    ready_next     = ready_flag;
    untimed_next   = untimed_flag;
    first_next     = first_flag;
    suspended_next = suspended_flag;
    mem_we         = 1'b0;
    mem_wdata      = '0;
    res_status     = indexed && !in_range;
    res_disp       = 1'b0;
    res_first      = 1'b0;
    unique case (item_op) inside
      ptdt_pkg::OP_TICK: begin
        tick_next = tick_count + 32'd1;
      end
      ptdt_pkg::OP_CREATE, ptdt_pkg::OP_UPDATE: begin
        if (in_range) begin
          untimed_next[aw] = (item_period == '0);
          ready_next[aw]   = 1'b1;
          mem_we           = 1'b1;
          mem_wdata.period = item_period;
          mem_wdata.due    = (item_op == ptdt_pkg::OP_CREATE) ? item_period
                                                              : tick_count + item_period;
        end
      end
      ptdt_pkg::OP_SUSPEND: begin
        if (in_range) suspended_next[aw] = 1'b1;
      end
      ptdt_pkg::OP_RESUME: begin
        if (in_range) suspended_next[aw] = 1'b0;
      end
      ptdt_pkg::OP_POLL: begin
        if (in_range) begin
          if (untimed_flag[aw]) begin
            res_disp       = !suspended_flag[aw];
            res_first      = first_flag[aw];
            first_next[aw] = 1'b0;
          end else if (tick_count > ptdt_pkg::WRAP_LIMIT) begin
            // wipe the schedule; every slot now reads as never armed
            ready_next   = '0;
            untimed_next = '0;
            tick_next    = '0;
          end else if (ready_flag[aw] && (mem_rdata.due <= tick_count)) begin
            mem_we           = 1'b1;
            mem_wdata.period = mem_rdata.period;
            mem_wdata.due    = tick_count + mem_rdata.period;
            res_disp         = !suspended_flag[aw];
            res_first        = first_flag[aw];
            first_next[aw]   = 1'b0;
          end
        end
      end
      default: ;
    endcase
    // drop the write unless the slot update really commits this cycle
    if (!exec_fire) mem_we = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ptdt_pkg::S_IDLE;
      task_count     <= '0;
      tick_count     <= '0;
      ready_flag     <= '0;
      untimed_flag   <= '0;
      first_flag     <= '1;
      suspended_flag <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) task_count <= cfg_wr_data;
      if (exec_fire) begin
        tick_count     <= tick_next;
        ready_flag     <= ready_next;
        untimed_flag   <= untimed_next;
        first_flag     <= first_next;
        suspended_flag <= suspended_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_op     <= op;
      item_index  <= task_index;
      item_period <= period;
    end
    if (exec_fire) begin
      status        <= res_status;
      dispatched    <= res_disp;
      first_run     <= res_first;
      slot_out      <= item_index;
      tick_snapshot <= tick_next;
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("second transfer taken while an item is in flight");

  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !dispatched && !first_run)
    else $error("rejected item reports a dispatch");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> in_range && exec_fire)
    else $error("slot memory written for a rejected index");

  a_wrap_clear: assert property (@(posedge clk) disable iff (rst)
    exec_fire && (item_op == ptdt_pkg::OP_POLL) && in_range && !untimed_flag[aw]
      && (tick_count > ptdt_pkg::WRAP_LIMIT)
    |=> (tick_count == '0) && (ready_flag == '0) && !dispatched)
    else $error("wrap clear did not reset the schedule");

endmodule
